/* rtl/fdc_pkg.sv */
// Shared types and constants for the floppy disk controller core.
package fdc_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Register addresses
    localparam logic [1:0] ADDR_CMD    = 2'd0;
    localparam logic [1:0] ADDR_TRACK  = 2'd1;
    localparam logic [1:0] ADDR_SECTOR = 2'd2;
    localparam logic [1:0] ADDR_DATA   = 2'd3;

    // Drive seek answers
    localparam logic [1:0] SEEK_FOUND     = 2'd0;
    localparam logic [1:0] SEEK_NO_DISK   = 2'd1;
    localparam logic [1:0] SEEK_NO_SECTOR = 2'd2;
    localparam logic [1:0] SEEK_UNKNOWN   = 2'd3;

    // Status bit masks
    localparam logic [7:0] ST_BUSY   = 8'h01;
    localparam logic [7:0] ST_DRQ    = 8'h02;
    localparam logic [7:0] ST_TR00   = 8'h04;
    localparam logic [7:0] ST_LOST   = 8'h04;
    localparam logic [7:0] ST_CRC    = 8'h08;
    localparam logic [7:0] ST_RNF    = 8'h10;
    localparam logic [7:0] ST_HLD    = 8'h20;
    localparam logic [7:0] ST_RTYPE  = 8'h20;
    localparam logic [7:0] ST_WFAULT = 8'h20;
    localparam logic [7:0] ST_WPROT  = 8'h40;
    localparam logic [7:0] ST_NRDY   = 8'h80;

    // Command groups (upper nibble of the command byte)
    localparam logic [3:0] CMD_RESTORE   = 4'h0;
    localparam logic [3:0] CMD_SEEK      = 4'h1;
    localparam logic [3:0] CMD_STEP_A    = 4'h2;
    localparam logic [3:0] CMD_STEP_B    = 4'h3;
    localparam logic [3:0] CMD_STEPIN_A  = 4'h4;
    localparam logic [3:0] CMD_STEPIN_B  = 4'h5;
    localparam logic [3:0] CMD_STEPOUT_A = 4'h6;
    localparam logic [3:0] CMD_STEPOUT_B = 4'h7;
    localparam logic [3:0] CMD_RSECT_A   = 4'h8;
    localparam logic [3:0] CMD_RSECT_B   = 4'h9;
    localparam logic [3:0] CMD_WSECT_A   = 4'hA;
    localparam logic [3:0] CMD_WSECT_B   = 4'hB;
    localparam logic [3:0] CMD_FORCE_INT = 4'hD;

    localparam logic [23:0] MAX24 = 24'hFF_FFFF;

    typedef enum logic [2:0] {
        OP_IDLE    = 3'd0,
        OP_RESTORE = 3'd1,
        OP_SEEK    = 3'd2,
        OP_STEP    = 3'd3,
        OP_RSECT   = 3'd4,
        OP_WSECT   = 3'd5,
        OP_RBYTE   = 3'd6,
        OP_WBYTE   = 3'd7
    } op_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  track;
        logic [7:0]  sector;
        logic [7:0]  data;
        logic [7:0]  command;
        op_t         op;
        logic [23:0] wait_count;
        logic        step_outward;
        logic        head_loaded;
        logic [23:0] unload_count;
        logic [10:0] byte_count;
        logic [10:0] sect_len;
        logic        intr;
        logic        pend_valid;
        logic [1:0]  pend_addr;
        logic [7:0]  pend_data;
        logic [15:0] pend_count;
        logic        drive_latched;
    } fdc_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  address;
        logic [7:0]  write_data;
        logic [7:0]  elapsed;
        logic        drive_selected;
        logic        drive_protected;
        logic [1:0]  seek_status;
        logic [10:0] sector_bytes;
        logic [7:0]  disk_data;
    } fdc_item_t;

    typedef struct packed {
        logic [7:0] disk_write_byte;
        logic       disk_write_strobe;
        logic       disk_read_strobe;
        logic [7:0] seek_sector;
        logic [7:0] seek_track;
        logic       seek_request;
        logic       busy_res;
        logic       head_load;
        logic       drq;
        logic       intrq;
        logic [7:0] read_data;
    } fdc_result_t;

endpackage

/* rtl/floppy_disk_controller_core_unit.sv */
// Top level of the floppy disk controller core: stream ports and state registers.
//
// Usage: every word on the slave channel is a tick, a bus read or a bus write
// (kind in s_tuser). Each accepted word yields exactly one result word on the
// master channel carrying the read data, the interrupt, data request, head
// load and busy levels, and the drive strobes for that word.
// The drive answers a seek request within the same word: seek_status and
// sector_bytes of the word that causes a request are the answer to it.
// The result is registered: it appears on m_tvalid in the cycle after the word is accepted.
// Throughput: one word per cycle unless the receiver stalls; the controller
// step is a single combinational pass between the state and result registers.
// When the receiver stalls, the result register holds its word and s_tready
// stays high only while the result register is empty or being drained in the
// same cycle, so no result is dropped.
// Reset (aresetn low, synchronous) clears all controller registers: idle, no
// pending write, head unloaded, and empties the result register.
module floppy_disk_controller_core_unit #(
    parameter int STEP_DELAY        = 6000,
    parameter int RESTORE_DELAY     = 6000,
    parameter int SECTOR_DELAY      = 1000,
    parameter int BYTE_DELAY        = 32,
    parameter int HEAD_UNLOAD_DELAY = 100000,
    parameter int WRITE_DELAY       = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[1:0], write_data[9:2], elapsed[17:10], drive_selected[18],
    // drive_protected[19], seek_status[21:20], sector_bytes[32:22], disk_data[40:33]
    input  logic [47:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], intrq[8], drq[9], head_load[10], busy_res[11],
    // seek_request[12], seek_track[20:13], seek_sector[28:21],
    // disk_read_strobe[29], disk_write_strobe[30], disk_write_byte[38:31]
    output logic [39:0] m_tdata
);
    import fdc_pkg::*;

    fdc_state_t  state_reg, state_next;
    fdc_item_t   item;
    fdc_result_t res;
    logic [38:0] result_reg;
    logic        valid_reg;
    logic        s_fire;

    // Unpack the input word
    assign item = '{kind:            s_tuser,
                    address:         s_tdata[1:0],
                    write_data:      s_tdata[9:2],
                    elapsed:         s_tdata[17:10],
                    drive_selected:  s_tdata[18],
                    drive_protected: s_tdata[19],
                    seek_status:     s_tdata[21:20],
                    sector_bytes:    s_tdata[32:22],
                    disk_data:       s_tdata[40:33]};

    assign s_tready = !valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    fdc_step #(
        .STEP_DELAY        (STEP_DELAY),
        .RESTORE_DELAY     (RESTORE_DELAY),
        .SECTOR_DELAY      (SECTOR_DELAY),
        .BYTE_DELAY        (BYTE_DELAY),
        .HEAD_UNLOAD_DELAY (HEAD_UNLOAD_DELAY),
        .WRITE_DELAY       (WRITE_DELAY)
    ) u_step (
        .cur  (state_reg),
        .item (item),
        .nxt  (state_next),
        .res  (res)
    );

    // Advance controller state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_fire) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, result_reg};

    // Busy status tracks a running operation
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.status[0] == (state_reg.op != OP_IDLE))
        else $error("busy bit and operation disagree");

    // An unloaded head has no unload countdown
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.head_loaded |-> state_reg.unload_count == 24'd0)
        else $error("unload countdown with head unloaded");

    // Read transfer never runs past the sector size
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.op == OP_RBYTE |-> state_reg.byte_count <= state_reg.sect_len)
        else $error("byte count beyond sector size");

    // Every accepted word produces a result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> valid_reg)
        else $error("accepted word without result");

endmodule

/* rtl/fdc_step.sv */
// Next-state and result logic for one controller word.
module fdc_step #(
    parameter int STEP_DELAY        = 6000,
    parameter int RESTORE_DELAY     = 6000,
    parameter int SECTOR_DELAY      = 1000,
    parameter int BYTE_DELAY        = 32,
    parameter int HEAD_UNLOAD_DELAY = 100000,
    parameter int WRITE_DELAY       = 0
) (
    input  fdc_pkg::fdc_state_t  cur,
    input  fdc_pkg::fdc_item_t   item,
    output fdc_pkg::fdc_state_t  nxt,
    output fdc_pkg::fdc_result_t res
);
    import fdc_pkg::*;

    localparam logic [23:0] STEP_C    = 24'(STEP_DELAY);
    localparam logic [23:0] RESTORE_C = 24'(RESTORE_DELAY);
    localparam logic [23:0] SECTOR_C  = 24'(SECTOR_DELAY);
    localparam logic [23:0] BYTE_C    = 24'(BYTE_DELAY);
    localparam logic [23:0] UNLOAD_C  = 24'(HEAD_UNLOAD_DELAY);
    localparam logic [15:0] WRITE_C   = 16'(WRITE_DELAY);

    fdc_state_t  s;
    fdc_result_t r;
    logic        wr_en;
    logic [1:0]  wa;
    logic [7:0]  wd;
    logic [7:0]  track_gap;
    logic [31:0] prod;
    logic        no_disk;
    logic        rd_op;
    logic        found;
    logic        type1_done;

    assign no_disk = (item.seek_status == SEEK_NO_DISK) || (item.seek_status == SEEK_UNKNOWN);

    always_comb begin
        s     = cur;
        r     = '0;
        wr_en = 1'b0;
        wa    = item.address;
        wd    = item.write_data;
        track_gap = '0;
        prod  = '0;
        rd_op = 1'b0;
        found = 1'b0;
        type1_done = 1'b0;

        // Bus side: deferred write countdown, reads, direct writes
        case (item.kind)
            KIND_TICK: begin
                if (s.pend_valid) begin
                    s.pend_count = (s.pend_count > 16'(item.elapsed)) ?
                                   s.pend_count - 16'(item.elapsed) : 16'd0;
                    if (s.pend_count == 16'd0) begin
                        s.pend_valid = 1'b0;
                        wr_en = 1'b1;
                        wa    = s.pend_addr;
                        wd    = s.pend_data;
                    end
                end
            end
            KIND_READ: begin
                if (item.address == ADDR_DATA) s.status = s.status & ~ST_DRQ;
                if (item.address == ADDR_CMD) s.intr = 1'b0;
                case (item.address)
                    ADDR_CMD:    r.read_data = s.status;
                    ADDR_TRACK:  r.read_data = s.track;
                    ADDR_SECTOR: r.read_data = s.sector;
                    default:     r.read_data = s.data;
                endcase
            end
            KIND_WRITE: begin
                if (WRITE_C != 16'd0) begin
                    s.pend_valid = 1'b1;
                    s.pend_addr  = item.address;
                    s.pend_data  = item.write_data;
                    s.pend_count = WRITE_C;
                end else begin
                    wr_en = 1'b1;
                end
            end
            default: ;
        endcase

        // Register write and command start
        if (wr_en) begin
            case (wa)
                ADDR_CMD: begin
                    s.command       = wd;
                    s.intr          = 1'b0;
                    s.drive_latched = item.drive_selected;
                    case (wd[7:4])
                        CMD_RESTORE: begin
                            s.wait_count = RESTORE_C;
                            s.op = OP_RESTORE;
                            s.status = s.status | ST_BUSY;
                        end
                        CMD_SEEK: begin
                            track_gap = (s.track > s.data) ? s.track - s.data :
                                        s.data - s.track;
                            prod = {8'd0, STEP_C} * {24'd0, track_gap};
                            s.wait_count = (prod[31:24] != 8'd0) ? MAX24 : prod[23:0];
                            s.op = OP_SEEK;
                            s.status = s.status | ST_BUSY;
                        end
                        CMD_STEP_A, CMD_STEP_B,
                        CMD_STEPIN_A, CMD_STEPIN_B,
                        CMD_STEPOUT_A, CMD_STEPOUT_B: begin
                            if (wd[7:5] == 3'd2) s.step_outward = 1'b0;
                            if (wd[7:5] == 3'd3) s.step_outward = 1'b1;
                            s.wait_count = STEP_C;
                            s.op = OP_STEP;
                            s.status = s.status | ST_BUSY;
                        end
                        CMD_RSECT_A, CMD_RSECT_B, CMD_WSECT_A, CMD_WSECT_B: begin
                            if (!wd[4]) begin
                                s.wait_count = SECTOR_C;
                                s.op = wd[5] ? OP_WSECT : OP_RSECT;
                                s.status = s.status | ST_BUSY;
                                s.head_loaded  = 1'b1;
                                s.unload_count = UNLOAD_C;
                            end
                        end
                        CMD_FORCE_INT: begin
                            s.status = s.status & ~(ST_BUSY | ST_DRQ);
                            s.op = OP_IDLE;
                            s.wait_count = '0;
                        end
                        default: begin
                            s.head_loaded  = 1'b1;
                            s.unload_count = UNLOAD_C;
                            s.status = s.status | ST_NRDY;
                            s.intr = 1'b1;
                        end
                    endcase
                end
                ADDR_TRACK:  s.track  = wd;
                ADDR_SECTOR: s.sector = wd;
                default: begin
                    s.data   = wd;
                    s.status = s.status & ~ST_DRQ;
                end
            endcase
        end

        // Tick: count the delay down, or run the command step
        if (item.kind == KIND_TICK) begin
            if (s.wait_count != 24'd0) begin
                s.wait_count = (s.wait_count > 24'(item.elapsed)) ?
                               s.wait_count - 24'(item.elapsed) : 24'd0;
            end else begin
                case (s.op)
                    OP_RESTORE: begin
                        s.track = '0;
                        type1_done = 1'b1;
                    end
                    OP_SEEK: begin
                        s.track = s.data;
                        type1_done = 1'b1;
                    end
                    OP_STEP: begin
                        if (s.command[4]) s.track = s.step_outward ? s.track - 8'd1 : s.track + 8'd1;
                        type1_done = 1'b1;
                    end
                    OP_RSECT, OP_WSECT: begin
                        rd_op = (s.op == OP_RSECT);
                        if (s.drive_latched) begin
                            r.seek_request = 1'b1;
                            r.seek_track   = s.track;
                            r.seek_sector  = s.sector;
                        end
                        found = s.drive_latched && (item.seek_status == SEEK_FOUND) &&
                                (item.sector_bytes != 11'd0);
                        if (found && (rd_op || !item.drive_protected)) begin
                            s.wait_count  = BYTE_C;
                            s.op          = rd_op ? OP_RBYTE : OP_WBYTE;
                            s.byte_count  = '0;
                            s.sect_len    = item.sector_bytes;
                            if (!rd_op) s.status = s.status | ST_DRQ;
                        end else begin
                            s.status = s.status & ~(ST_BUSY | ST_LOST | ST_CRC);
                            s.intr = 1'b1;
                            s.op = OP_IDLE;
                            if (s.drive_latched && item.seek_status == SEEK_NO_SECTOR)
                                s.status = s.status | ST_RNF;
                            else if (rd_op || !s.drive_latched || no_disk)
                                s.status = s.status | ST_NRDY;
                            else
                                s.status = s.status | ST_WPROT;
                        end
                    end
                    OP_RBYTE: begin
                        if ((s.status & ST_DRQ) == 8'd0) begin
                            if (s.byte_count < s.sect_len) begin
                                s.data = item.disk_data;
                                r.disk_read_strobe = 1'b1;
                                s.byte_count = s.byte_count + 11'd1;
                                s.status = s.status | ST_DRQ;
                            end else begin
                                s.status = s.status & ~(ST_BUSY | ST_LOST | ST_CRC);
                                s.intr = 1'b1;
                                s.op = OP_IDLE;
                                s.status = s.status & ~(ST_WPROT | ST_RTYPE);
                            end
                        end
                    end
                    OP_WBYTE: begin
                        if ((s.status & ST_DRQ) == 8'd0) begin
                            r.disk_write_strobe = 1'b1;
                            r.disk_write_byte   = s.data;
                            s.byte_count = s.byte_count + 11'd1;
                            if (s.byte_count < s.sect_len) begin
                                s.status = s.status | ST_DRQ;
                            end else begin
                                s.status = s.status & ~(ST_BUSY | ST_LOST | ST_CRC);
                                s.intr = 1'b1;
                                s.op = OP_IDLE;
                                s.status = s.status & ~ST_WFAULT;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // Finish a positioning command
            if (type1_done) begin
                s.status = s.status & ~ST_BUSY;
                s.head_loaded  = s.command[3];
                s.unload_count = s.command[3] ? UNLOAD_C : 24'd0;
                s.status = s.head_loaded ? (s.status | ST_HLD) : (s.status & ~ST_HLD);
                s.status = (s.track == 8'd0) ? (s.status | ST_TR00) : (s.status & ~ST_TR00);
                if (s.drive_latched) begin
                    r.seek_request = 1'b1;
                    r.seek_track   = s.track;
                    r.seek_sector  = 8'd1;
                    s.status = no_disk ? (s.status | ST_NRDY) : (s.status & ~ST_NRDY);
                    s.status = item.drive_protected ? (s.status | ST_WPROT) :
                               (s.status & ~ST_WPROT);
                end else begin
                    s.status = s.status | ST_NRDY | ST_WPROT;
                end
                s.intr = 1'b1;
                s.op = OP_IDLE;
            end

            // Drop the head some time after the last command
            if (s.head_loaded && s.op == OP_IDLE && s.unload_count != 24'd0) begin
                s.unload_count = (s.unload_count > 24'(item.elapsed)) ?
                                 s.unload_count - 24'(item.elapsed) : 24'd0;
                if (s.unload_count == 24'd0) s.head_loaded = 1'b0;
            end
        end

        r.intrq     = s.intr;
        r.drq       = s.status[1];
        r.head_load = s.head_loaded;
        r.busy_res  = s.status[0];
    end

    assign nxt = s;
    assign res = r;

endmodule
